[rtl/idw_warp_coordinate_map_unit_macros.svh]
// Assertion macros for the warp coordinate map unit.
`ifndef IDW_WARP_COORDINATE_MAP_UNIT_MACROS_SVH
`define IDW_WARP_COORDINATE_MAP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define IDW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("idw assertion failed");
`define IDW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("idw assertion failed");
`else
`define IDW_ASSERT(lbl, prop)
`define IDW_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/idw_pkg.sv]
package idw_pkg;

  localparam int CoordW  = 12;
  localparam int OffW    = 13;
  localparam int SrcW    = 14;
  localparam int SqW     = 34;
  localparam int RootW   = 33;
  localparam int RootIt  = 33;
  localparam int DivW    = 64;
  localparam int WeightW = 48;
  localparam int HalfW   = 24;
  localparam int EpsW    = 16;
  localparam int DimW    = 13;
  localparam int PcW     = 5;

  localparam logic [1:0] RegPointCount = 2'd0;
  localparam logic [1:0] RegImgWidth   = 2'd1;
  localparam logic [1:0] RegImgHeight  = 2'd2;
  localparam logic [1:0] RegEps        = 2'd3;

  localparam logic OpLoad = 1'b0;
  localparam logic OpMap  = 1'b1;

  // One control point: end point and offset (start minus end).
  typedef struct packed {
    logic [CoordW-1:0]      ex;
    logic [CoordW-1:0]      ey;
    logic signed [OffW-1:0] ox;
    logic signed [OffW-1:0] oy;
  } cell_t;

endpackage

[rtl/idw_warp_coordinate_map_unit.sv]
// Inverse-distance-weighted backward warp, coordinate stage.
// Input stream (s_axis): tuser = opcode. A load item (opcode 0) writes one
// control point slot and gives no result; a map item (opcode 1) gives one
// result item on m_axis: source_x/source_y in tdata, inside flag in tuser.
// Control points live in a ring of MAX_POINTS cells. A map item rotates the
// ring once around, so each point passes cell 0 where the shared root unit,
// multiplier and iterative divider compute its weight 1/(d+eps)^2 and the
// weighted offsets. For each active point (point_count clamped to
// MAX_POINTS) the item runs the root, the weight division and five control
// steps; an idle slot only rotates the ring; after the ring closes, two final
// divisions give the source coordinates. The next item can be accepted in
// the cycle after the result is loaded. A load item writes its slot when it
// is accepted and leaves the block idle. One item is in work at a time.
// While m_axis_tready is low the output register holds the finished result;
// the block still accepts the next item and works on it, but holds it before
// its last division until the output register is free.
// Reset clears control state and the APB registers to point_count 0,
// width 640, height 480, eps 7; point slots are undefined until loaded.
// APB: point_count @0x0, image_width @0x4, image_height @0x8, eps @0xC.
module idw_warp_coordinate_map_unit #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: slot[3:0], start_x[15:4], start_y[27:16], end_x[39:28],
  //        end_y[51:40], pixel_x[63:52], pixel_y[75:64], zero pad
  input  logic [79:0] s_axis_tdata,
  // tuser: opcode
  input  logic        s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: source_x[13:0], source_y[27:14], zero pad
  output logic [31:0] m_axis_tdata,
  // tuser: inside_res
  output logic        m_axis_tuser
);
  import idw_pkg::*;
  `include "idw_warp_coordinate_map_unit_macros.svh"

  localparam int PtW = $clog2(MAX_POINTS + 1);
  localparam int CmpW = (PtW > PcW) ? PtW : PcW;
  localparam int ProdW = HalfW + CoordW;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_PT   = 12'b000000000010,
    S_DIST = 12'b000000000100,
    S_ROOT = 12'b000000001000,
    S_SQR  = 12'b000000010000,
    S_WDIV = 12'b000000100000,
    S_MUL  = 12'b000001000000,
    S_ACC  = 12'b000010000000,
    S_XS   = 12'b000100000000,
    S_XW   = 12'b001000000000,
    S_YS   = 12'b010000000000,
    S_YW   = 12'b100000000000
  } state_e;

  // ---------------- configuration ----------------
  logic [PcW-1:0]  pc_q;
  logic [DimW-1:0] iw_q, ih_q;
  logic [EpsW-1:0] eps_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      iw_q  <= DimW'(640);
      ih_q  <= DimW'(480);
      eps_q <= EpsW'(7);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegPointCount: pc_q  <= pwdata[PcW-1:0];
        RegImgWidth:   iw_q  <= pwdata[DimW-1:0];
        RegImgHeight:  ih_q  <= pwdata[DimW-1:0];
        RegEps:        eps_q <= pwdata[EpsW-1:0];
        default:       pc_q  <= pc_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegPointCount: prdata = {{(32-PcW){1'b0}}, pc_q};
      RegImgWidth:   prdata = {{(32-DimW){1'b0}}, iw_q};
      RegImgHeight:  prdata = {{(32-DimW){1'b0}}, ih_q};
      RegEps:        prdata = {{(32-EpsW){1'b0}}, eps_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------- control point ring ----------------
  logic  in_acc, ld_en, ring_shift;
  cell_t ld_data;
  cell_t cell_q [MAX_POINTS];

  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign ld_en  = in_acc & (s_axis_tuser == OpLoad);
  assign ld_data.ex = s_axis_tdata[39:28];
  assign ld_data.ey = s_axis_tdata[51:40];
  assign ld_data.ox = $signed({1'b0, s_axis_tdata[15:4]}) - $signed({1'b0, s_axis_tdata[39:28]});
  assign ld_data.oy = $signed({1'b0, s_axis_tdata[27:16]}) - $signed({1'b0, s_axis_tdata[51:40]});

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    idw_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (ring_shift),
      .load_i      (ld_en && (int'(s_axis_tdata[3:0]) == k)),
      .nbr_i       (cell_q[(k + 1) % MAX_POINTS]),
      .load_data_i (ld_data),
      .q_o         (cell_q[k])
    );
  end

  // ---------------- sequencer ----------------
  state_e              state_q, state_d;
  logic [PtW-1:0]      pt_q, pt_d;
  logic [CoordW-1:0]   px_q, py_q;
  logic [DivW-1:0]     posx_q, negx_q, posy_q, negy_q, wsum_q;
  logic [DivW-1:0]     posx_d, negx_d, posy_d, negy_d, wsum_d;
  logic [WeightW-1:0]  w_q, w_d;
  logic [ProdW-1:0]    hx_q, lx_q, hy_q, ly_q;
  logic                sgx_q, sgy_q;
  logic signed [SrcW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic                ov_q, ov_d, oin_q;
  logic signed [SrcW-1:0] osx_q, osy_q;
  logic                out_load;

  // distance and weight datapath
  logic [CoordW-1:0]   adx, ady;
  logic [SqW-1:0]      sq;
  logic                root_start, root_busy, root_done;
  logic [RootW-1:0]    root;
  logic [RootW:0]      qd;
  logic [DivW-1:0]     den_w;
  logic                div_start, div_busy, div_done;
  logic [DivW-1:0]     div_num, div_den, quo;
  logic [DivW-1:0]     diffx, diffy;
  logic [DivW-1:0]     prodx, prody;

  function automatic logic [DivW-1:0] sat_add(input logic [DivW-1:0] a,
                                              input logic [DivW-1:0] b);
    logic [DivW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DivW] ? '1 : s[DivW-1:0];
  endfunction

  // pixel plus signed quotient, clamped to the source range
  function automatic logic signed [SrcW-1:0] finish(input logic [CoordW-1:0] p,
                                                    input logic [DivW-1:0] q,
                                                    input logic neg,
                                                    input logic wzero);
    logic [SrcW-1:0]        mag;
    logic signed [SrcW+2:0] s;
    mag = (wzero) ? '0 : ((q[DivW-1:SrcW] != '0) ? '1 : q[SrcW-1:0]);
    if (neg) s = $signed({5'b0, p}) - $signed({3'b0, mag});
    else     s = $signed({5'b0, p}) + $signed({3'b0, mag});
    if (s < -(SrcW+3)'(8192))     return SrcW'(-8192);
    else if (s > (SrcW+3)'(8191)) return SrcW'(8191);
    else                          return s[SrcW-1:0];
  endfunction

  assign adx = (cell_q[0].ex >= px_q) ? cell_q[0].ex - px_q : px_q - cell_q[0].ex;
  assign ady = (cell_q[0].ey >= py_q) ? cell_q[0].ey - py_q : py_q - cell_q[0].ey;
  assign sq  = SqW'({12'b0, adx} * {12'b0, adx}) + SqW'({12'b0, ady} * {12'b0, ady});
  assign root_start = (state_q == S_DIST);

  idw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .sq_i    (sq),
    .busy_o  (root_busy),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign qd    = {1'b0, root} + {{(RootW+1-EpsW){1'b0}}, eps_q};
  assign den_w = (qd[RootW:32] != '0) ? '1 : (qd[31:0] * qd[31:0]);
  assign diffx = (posx_q >= negx_q) ? posx_q - negx_q : negx_q - posx_q;
  assign diffy = (posy_q >= negy_q) ? posy_q - negy_q : negy_q - posy_q;

  always_comb begin
    div_start = 1'b0;
    div_num   = '1;
    div_den   = den_w;
    unique case (state_q)
      S_SQR: div_start = 1'b1;
      S_XS: begin
        div_start = 1'b1;
        div_num   = diffx;
        div_den   = wsum_q;
      end
      S_YS: begin
        // start only once the output register is free
        div_start = ~ov_q;
        div_num   = diffy;
        div_den   = wsum_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  idw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign prodx = ({{(DivW-ProdW){1'b0}}, hx_q} << HalfW) + {{(DivW-ProdW){1'b0}}, lx_q};
  assign prody = ({{(DivW-ProdW){1'b0}}, hy_q} << HalfW) + {{(DivW-ProdW){1'b0}}, ly_q};

  assign s_axis_tready = (state_q == S_IDLE) & ~(ov_q & (state_q != S_IDLE));
  assign out_load      = (state_q == S_YW) & div_done;

  always_comb begin
    state_d    = state_q;
    pt_d       = pt_q;
    posx_d     = posx_q;
    negx_d     = negx_q;
    posy_d     = posy_q;
    negy_d     = negy_q;
    wsum_d     = wsum_q;
    w_d        = w_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    ring_shift = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser == OpMap)) begin
          pt_d    = '0;
          posx_d  = '0;
          negx_d  = '0;
          posy_d  = '0;
          negy_d  = '0;
          wsum_d  = '0;
          state_d = S_PT;
        end
      end
      S_PT: begin
        if (pt_q == PtW'(MAX_POINTS)) begin
          state_d = S_XS;
        end else if (CmpW'(pt_q) < CmpW'(pc_q)) begin
          state_d = S_DIST;
        end else begin
          // inactive slot: only rotate so the ring ends where it began
          ring_shift = 1'b1;
          pt_d       = pt_q + 1'b1;
        end
      end
      S_DIST: state_d = S_ROOT;
      S_ROOT: if (root_done) state_d = S_SQR;
      S_SQR:  state_d = S_WDIV;
      S_WDIV: begin
        if (div_done) begin
          w_d     = (quo[DivW-1:WeightW] != '0) ? '1 : quo[WeightW-1:0];
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_ACC;
      S_ACC: begin
        wsum_d = wsum_q + {{(DivW-WeightW){1'b0}}, w_q};
        if (sgx_q) negx_d = sat_add(negx_q, prodx);
        else       posx_d = sat_add(posx_q, prodx);
        if (sgy_q) negy_d = sat_add(negy_q, prody);
        else       posy_d = sat_add(posy_q, prody);
        ring_shift = 1'b1;
        pt_d       = pt_q + 1'b1;
        state_d    = S_PT;
      end
      S_XS:   state_d = S_XW;
      S_XW: begin
        if (div_done) begin
          sx_d    = finish(px_q, quo, negx_q > posx_q, wsum_q == '0);
          state_d = S_YS;
        end
      end
      S_YS: begin
        // the output register must be free before the last division ends
        if (!ov_q) state_d = S_YW;
      end
      S_YW: begin
        if (div_done) begin
          sy_d    = finish(py_q, quo, negy_q > posy_q, wsum_q == '0);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (m_axis_tvalid && m_axis_tready) ov_d = 1'b0;
    if (out_load) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pt_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pt_q    <= pt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    posx_q <= posx_d;
    negx_q <= negx_d;
    posy_q <= posy_d;
    negy_q <= negy_d;
    wsum_q <= wsum_d;
    w_q    <= w_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    if (in_acc) begin
      px_q <= s_axis_tdata[63:52];
      py_q <= s_axis_tdata[75:64];
    end
    if (state_q == S_MUL) begin
      hx_q  <= w_q[WeightW-1:HalfW] * (cell_q[0].ox[OffW-1] ? CoordW'(-cell_q[0].ox)
                                                            : CoordW'(cell_q[0].ox));
      lx_q  <= w_q[HalfW-1:0] * (cell_q[0].ox[OffW-1] ? CoordW'(-cell_q[0].ox)
                                                      : CoordW'(cell_q[0].ox));
      hy_q  <= w_q[WeightW-1:HalfW] * (cell_q[0].oy[OffW-1] ? CoordW'(-cell_q[0].oy)
                                                            : CoordW'(cell_q[0].oy));
      ly_q  <= w_q[HalfW-1:0] * (cell_q[0].oy[OffW-1] ? CoordW'(-cell_q[0].oy)
                                                      : CoordW'(cell_q[0].oy));
      sgx_q <= cell_q[0].ox[OffW-1];
      sgy_q <= cell_q[0].oy[OffW-1];
    end
    if (out_load) begin
      osx_q <= sx_q;
      osy_q <= sy_d;
      oin_q <= (sx_q >= 0) && (sy_d >= 0) &&
               ({1'b0, sx_q[SrcW-2:0]} < {1'b0, iw_q}) &&
               ({1'b0, sy_d[SrcW-2:0]} < {1'b0, ih_q});
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0, osy_q, osx_q};
  assign m_axis_tuser  = oin_q;

  // ---------------- checks ----------------
  `IDW_ASSERT(a_pt_range, pt_q <= PtW'(MAX_POINTS))
  `IDW_ASSERT(a_div_idle_start, div_start |-> !div_busy)
  `IDW_ASSERT(a_root_idle_start, root_start |-> !root_busy)
  `IDW_ASSERT(a_out_from_seq, $rose(m_axis_tvalid) |-> $past(state_q == S_YW))
  `IDW_ASSERT(a_ring_home, (state_q == S_XS) |-> (pt_q == PtW'(MAX_POINTS)))

endmodule

[rtl/idw_cell.sv]
module idw_cell (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic          load_i,
  input  idw_pkg::cell_t nbr_i,
  input  idw_pkg::cell_t load_data_i,
  output idw_pkg::cell_t q_o
);
  import idw_pkg::*;

  cell_t pt_q, pt_d;

  // load and shift never coincide: loads come only while idle
  always_comb begin
    pt_d = pt_q;
    if (load_i) begin
      pt_d = load_data_i;
    end else if (shift_i) begin
      pt_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign q_o = pt_q;

endmodule

[rtl/idw_sqrt.sv]
module idw_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [idw_pkg::SqW-1:0]   sq_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [idw_pkg::RootW-1:0] root_o
);
  import idw_pkg::*;

  localparam int RemW = RootW + 3;
  localparam int CntW = $clog2(RootIt + 1);

  logic [SqW-1:0]   sq_q, sq_d;
  logic [RemW-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  // one result bit per cycle; sq is shifted out two bits at a time
  always_comb begin
    sq_d   = sq_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[RemW-3:0], sq_q[SqW-1:SqW-2]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      sq_d   = sq_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sq_d = {sq_q[SqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(RootIt - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/idw_div.sv]
module idw_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [idw_pkg::DivW-1:0] num_i,
  input  logic [idw_pkg::DivW-1:0] den_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [idw_pkg::DivW-1:0] quo_o
);
  import idw_pkg::*;

  localparam int CntW = $clog2(DivW);

  logic [DivW:0]   rem_q, rem_d, rem_sh;
  logic [DivW-1:0] quo_q, quo_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  // restoring division, one quotient bit per cycle; a zero divisor gives all ones
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[DivW-1:0], quo_q[DivW-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[test/idw_checker.sv]
module idw_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import idw_pkg::*;

  localparam int NumSlots = 16;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WeightMax = (64'd1 << WeightW) - 64'd1;

  typedef struct packed {
    logic [SrcW-1:0] sx;
    logic [SrcW-1:0] sy;
    logic            in_img;
  } coord_res_t;

  logic [PcW-1:0]  pc_q;
  logic [DimW-1:0] width_q, height_q;
  logic [EpsW-1:0] eps_q;
  cell_t           ring_q [NumSlots];
  coord_res_t      coord_q [$];

  function automatic logic [63:0] slot_weight(cell_t c, logic [CoordW-1:0] px,
                                              logic [CoordW-1:0] py, logic [EpsW-1:0] e);
    longint      dx, dy;
    logic [67:0] v, t;
    logic [33:0] root;
    logic [67:0] cand;
    logic [67:0] den;
    dx = longint'(c.ex) - longint'(px);
    dy = longint'(c.ey) - longint'(py);
    v = 68'(dx * dx + dy * dy) << 32;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = 68'(root | (34'd1 << b));
      t = cand * cand;
      if (t <= v) root = cand[33:0];
    end
    cand = 68'(root) + 68'(e);
    den = cand * cand;
    if (den == 0) return WeightMax;
    if (den > 68'(AllOnes)) den = 68'(AllOnes);
    slot_weight = AllOnes / den[63:0];
    if (slot_weight > WeightMax) slot_weight = WeightMax;
  endfunction

  function automatic logic [63:0] sat_acc(logic [63:0] acc, logic [63:0] w,
                                          logic [63:0] mag);
    logic [127:0] t;
    t = 128'(acc) + 128'(w) * 128'(mag);
    return (t > 128'(AllOnes)) ? AllOnes : t[63:0];
  endfunction

  function automatic logic [SrcW-1:0] source_of(logic [CoordW-1:0] p, logic [63:0] pos,
                                                 logic [63:0] neg, logic [63:0] wsum);
    logic [63:0] mag;
    longint      s;
    s = longint'(p);
    if (wsum != 0) begin
      mag = (pos >= neg) ? (pos - neg) / wsum : (neg - pos) / wsum;
      if (mag > 64'h10_0000) mag = 64'h10_0000;
      s = (pos >= neg) ? s + longint'(mag) : s - longint'(mag);
    end
    if (s < -8192) s = -8192;
    if (s > 8191) s = 8191;
    return s[SrcW-1:0];
  endfunction

  function automatic coord_res_t map_pixel(logic [CoordW-1:0] px, logic [CoordW-1:0] py);
    logic [63:0] pxs, nxs, pys, nys, wsum, w;
    int          n;
    coord_res_t  r;
    logic signed [SrcW-1:0] sx, sy;
    pxs = 0; nxs = 0; pys = 0; nys = 0; wsum = 0;
    n = (pc_q > NumSlots) ? NumSlots : int'(pc_q);
    for (int i = 0; i < n; i++) begin
      w = slot_weight(ring_q[i], px, py, eps_q);
      wsum = wsum + w;
      if (ring_q[i].ox >= 0) pxs = sat_acc(pxs, w, 64'(ring_q[i].ox));
      else nxs = sat_acc(nxs, w, 64'(-ring_q[i].ox));
      if (ring_q[i].oy >= 0) pys = sat_acc(pys, w, 64'(ring_q[i].oy));
      else nys = sat_acc(nys, w, 64'(-ring_q[i].oy));
    end
    sx = source_of(px, pxs, nxs, wsum);
    sy = source_of(py, pys, nys, wsum);
    r.sx = sx;
    r.sy = sy;
    r.in_img = sx >= 0 && sy >= 0 && int'(sx) < int'(width_q) && int'(sy) < int'(height_q);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_t      c;
    coord_res_t got, want;
    if (!rst_ni) begin
      pc_q <= '0;
      width_q <= 13'd640;
      height_q <= 13'd480;
      eps_q <= 16'd7;
      coord_q.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegPointCount: pc_q <= pwdata[PcW-1:0];
          RegImgWidth:   width_q <= pwdata[DimW-1:0];
          RegImgHeight:  height_q <= pwdata[DimW-1:0];
          RegEps:        eps_q <= pwdata[EpsW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OpLoad) begin
          c.ex = s_axis_tdata[39:28];
          c.ey = s_axis_tdata[51:40];
          c.ox = OffW'(s_axis_tdata[15:4]) - OffW'(c.ex);
          c.oy = OffW'(s_axis_tdata[27:16]) - OffW'(c.ey);
          ring_q[s_axis_tdata[3:0]] <= c;
        end else begin
          coord_q.insert(coord_q.size(),
                         map_pixel(s_axis_tdata[63:52], s_axis_tdata[75:64]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.sx = m_axis_tdata[13:0];
        got.sy = m_axis_tdata[27:14];
        got.in_img = m_axis_tuser;
        checked <= checked + 1;
        if (coord_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = coord_q.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("mismatch: exp sx %0d sy %0d in %0d, got sx %0d sy %0d in %0d",
                       $signed(want.sx), $signed(want.sy), want.in_img,
                       $signed(got.sx), $signed(got.sy), got.in_img);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = coord_q.size();

endmodule

[test/tb.sv]
module tb;
  import idw_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  // APB side, idle until a register write
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  // stream in: tdata slot/start/end/pixel from bit 0 up, tuser opcode
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  // stream out: tdata source_x, source_y from bit 0 up, tuser inside flag
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count, pending, checked;
  int tx_idle, rx_idle;   // idle percentages for sender and receiver
  int sent_items;

  always #4 clk_i = ~clk_i;

  idw_warp_coordinate_map_unit dut (.*);
  idw_checker u_checker (.*);

  // receiver stalls at random per cycle
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rx_idle);

  // one input item; tvalid stays high if the next item follows at once
  task automatic push_item(logic op, logic [3:0] slot, logic [11:0] sx, logic [11:0] sy,
                           logic [11:0] ex, logic [11:0] ey, logic [11:0] px,
                           logic [11:0] py);
    if ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'd0, py, px, ey, ex, sy, sx, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic load_slot(logic [3:0] slot, logic [11:0] sx, logic [11:0] sy,
                           logic [11:0] ex, logic [11:0] ey);
    push_item(OpLoad, slot, sx, sy, ex, ey, 12'($urandom), 12'($urandom));
  endtask

  task automatic map_px(logic [11:0] px, logic [11:0] py);
    push_item(OpMap, 4'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
              12'($urandom), px, py);
  endtask

  // registers move only while the block is quiet: no mapped result is pending,
  // and a margin of a full map latency is allowed on top
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [11:0] ax, ay;
    int          pc, map_pct;
    tx_idle = 10; rx_idle = 54;
    sent_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no points: identity, corners of the coordinate range and of the default image
    map_px(12'd0, 12'd0);
    map_px(12'hFFF, 12'hFFF);
    map_px(12'd639, 12'd479);
    // fill every slot so no active slot is ever unwritten
    load_slot(4'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF);
    load_slot(4'd1, 12'hFFF, 12'hFFF, 12'd0, 12'd0);
    for (int i = 2; i < 16; i++)
      load_slot(4'(i), 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    reg_write(RegPointCount, 32'd2);
    reg_write(RegEps, 32'd1);
    map_px(12'hFFF, 12'hFFF);          // pixel on an end point, tiny eps
    map_px(12'd0, 12'd0);
    reg_write(RegEps, 32'hFFFF);
    reg_write(RegImgWidth, 32'd0);     // empty image: nothing lies inside
    reg_write(RegImgHeight, 32'd4096);
    map_px(12'd2048, 12'd2048);
    reg_write(RegPointCount, 32'd31);  // clamps to all slots
    reg_write(RegImgWidth, 32'd1);
    map_px(12'd0, 12'd100);

    // random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin tx_idle = 54; rx_idle = 10; end
      if (ph == 6) begin tx_idle = 0; rx_idle = 0; end
      pc = (ph == 5) ? 16 : $urandom_range(4);
      map_pct = (pc == 16) ? 8 : 50;
      reg_write(RegPointCount, pc);
      reg_write(RegImgWidth, (ph == 1) ? 4096 : $urandom_range(4096, 1));
      reg_write(RegImgHeight, (ph == 2) ? 1 : $urandom_range(4096, 1));
      reg_write(RegEps, (ph == 4) ? 1 : $urandom_range(65535, 1));
      for (int k = 0; k < 228; k++) begin
        if ($urandom_range(99) < map_pct) begin
          // a random pixel, in most cases with random low bits flipped
          if ($urandom_range(3) == 0) map_px(12'($urandom), 12'($urandom));
          else begin
            ax = 12'($urandom); ay = 12'($urandom);
            map_px(ax ^ 12'($urandom_range(15)), ay ^ 12'($urandom_range(15)));
          end
        end else begin
          ax = 12'($urandom); ay = 12'($urandom);
          load_slot(4'($urandom), ax + 12'($urandom_range(255)) - 12'd128,
                    ay + 12'($urandom_range(255)) - 12'd128, ax, ay);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    $display("sent %0d items (loads and maps) over 8 register settings", sent_items);
    $display("checked %0d mapped coordinates under three idle patterns", checked);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
